### design/bfiq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfiq_pkg
// Shared constants and types for the bloom filter insert / query engine.
// ----------------------------------------------------------------------------
package bfiq_pkg;

    // bit array geometry
    localparam int MAP_WORDS  = 32768;
    localparam int MAX_PROBES = 69;
    localparam int WORD_W     = 32;
    localparam int ADDR_W     = $clog2(MAP_WORDS);
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int IDX_W      = ADDR_W + BIT_W;

    // field and register widths
    localparam int HASH_W = 64;
    localparam int TB_W   = 21;
    localparam int NH_W   = 7;
    localparam int CNT_W  = $clog2(HASH_W);

    // table size bounds
    localparam logic [TB_W-1:0] TABLE_CAP = TB_W'(MAP_WORDS * WORD_W);
    localparam logic [TB_W-1:0] TB_RESET  = TB_W'(1048576);
    localparam logic [NH_W-1:0] NH_RESET  = NH_W'(1);
    localparam logic [NH_W-1:0] NH_CAP    = NH_W'(MAX_PROBES);

    // bit select within a word
    localparam logic [BIT_W-1:0] BIT_SEL = BIT_W'(5'h1F);

    // commands
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // configuration register indexes
    localparam logic REG_TABLE_BITS = 1'b0;
    localparam logic REG_NUM_HASHES = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD_F,
        ST_MOD_S,
        ST_MOD_W,
        ST_RD,
        ST_CHK
    } t_state;

endpackage

`default_nettype wire

### design/bloom_filter_insert_query.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bloom_filter_insert_query
// Bloom filter bit array engine with double hashing probe sequence.
//
//  channel   ports                                  handshake
//  --------  -------------------------------------  ---------------------------
//  item in   i_cmd, i_hash_first, i_hash_second     start high, busy low
//  result    o_present                              o_valid, one cycle strobe
//  config    i_cfg_idx, i_cfg_data                  i_cfg_we, no wait
//
//  An item (at most 69 probes) goes through three serial
//  64-step remainder passes (first, second, 2^64 modulo m) on one shared
//  compare-subtract unit, then a read and a check/write of the bit array per
//  probe through its single port. A query stops at the first clear bit.
//  The result strobe comes in the first idle cycle, when start may be taken.
//  After reset the bit array is swept clear, one word a cycle, with busy
//  high. The receiver cannot stall.
// ----------------------------------------------------------------------------
module bloom_filter_insert_query
    import bfiq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_cmd,
    input  wire logic [HASH_W-1:0] i_hash_first,
    input  wire logic [HASH_W-1:0] i_hash_second,
    output logic                   o_valid,
    output logic                   o_present,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [TB_W-1:0]   i_cfg_data
);

    // control state
    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   r_present, n_present;

    // configuration
    logic [TB_W-1:0] r_table_bits;
    logic [NH_W-1:0] r_num_hashes;

    // datapath
    logic              r_cmd;
    logic [HASH_W-1:0] r_second;
    logic [HASH_W-1:0] r_acc;
    logic [HASH_W-1:0] r_sh;
    logic [IDX_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_smod;
    logic [IDX_W-1:0]  r_wmod;
    logic [IDX_W-1:0]  r_part;
    logic              r_carry;
    logic [NH_W-1:0]   r_probe;
    logic [ADDR_W-1:0] r_clr_addr;

    // bit array
    logic [WORD_W-1:0] mem [MAP_WORDS];
    logic [WORD_W-1:0] r_rdata;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    // combinational helpers
    logic [TB_W-1:0]   m_eff;
    logic [NH_W-1:0]   k_eff;
    logic [TB_W-1:0]   mod_t;
    logic [IDX_W-1:0]  mod_next;
    logic              mod_done;
    logic [TB_W-1:0]   step_sum;
    logic [IDX_W-1:0]  step_part;
    logic [HASH_W:0]   acc_sum;
    logic [IDX_W-1:0]  idx_next;
    logic              bit_hit;
    logic              probe_last;
    logic [WORD_W-1:0] bit_mask;

    // effective table size and probe count
    always_comb begin
        if (r_table_bits > TABLE_CAP) begin
            m_eff = TABLE_CAP;
        end else if (r_table_bits == '0) begin
            m_eff = TB_W'(1);
        end else begin
            m_eff = r_table_bits;
        end
        k_eff = (r_num_hashes > NH_CAP) ? NH_CAP : r_num_hashes;
    end

    // one restoring remainder step per cycle
    assign mod_t    = {r_rem, r_sh[HASH_W-1]};
    assign mod_next = (mod_t >= m_eff) ? IDX_W'(mod_t - m_eff) : IDX_W'(mod_t);
    assign mod_done = (r_cnt == CNT_W'(HASH_W - 1));

    // residue step: add the step residue, wrap at m
    assign step_sum  = TB_W'(r_idx) + TB_W'(r_smod);
    assign step_part = (step_sum >= m_eff) ? IDX_W'(step_sum - m_eff) : IDX_W'(step_sum);
    assign acc_sum   = {1'b0, r_acc} + {1'b0, r_second};

    // take out 2^64 mod m when the 64-bit sum wrapped
    always_comb begin
        if (!r_carry) begin
            idx_next = r_part;
        end else if (r_part >= r_wmod) begin
            idx_next = r_part - r_wmod;
        end else begin
            idx_next = IDX_W'(TB_W'(r_part) + m_eff - TB_W'(r_wmod));
        end
    end

    // probe check
    assign bit_mask   = WORD_W'(1) << (r_idx[BIT_W-1:0] & BIT_SEL);
    assign bit_hit    = |(r_rdata & bit_mask);
    assign probe_last = ({1'b0, r_probe} + (NH_W+1)'(1)) >= {1'b0, k_eff};

    // next state and result
    always_comb begin
        n_state   = r_state;
        n_valid   = 1'b0;
        n_present = r_present;
        unique case (r_state)
            ST_CLEAR: begin
                if (&r_clr_addr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_MOD_F;
                end
            end
            ST_MOD_F: begin
                if (mod_done) begin
                    n_state = ST_MOD_S;
                end
            end
            ST_MOD_S: begin
                if (mod_done) begin
                    n_state = ST_MOD_W;
                end
            end
            ST_MOD_W: begin
                if (mod_done) begin
                    if (k_eff == '0) begin
                        n_state   = ST_IDLE;
                        n_valid   = 1'b1;
                        n_present = (r_cmd == CMD_QUERY);
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD: begin
                n_state = ST_CHK;
            end
            ST_CHK: begin
                if (r_cmd == CMD_QUERY && !bit_hit) begin
                    n_state   = ST_IDLE;
                    n_valid   = 1'b1;
                    n_present = 1'b0;
                end else if (probe_last) begin
                    n_state   = ST_IDLE;
                    n_valid   = 1'b1;
                    n_present = (r_cmd == CMD_QUERY);
                end else begin
                    n_state = ST_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_valid   <= 1'b0;
            r_present <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_present <= n_present;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_bits <= TB_RESET;
            r_num_hashes <= NH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TABLE_BITS: r_table_bits <= i_cfg_data;
                REG_NUM_HASHES: r_num_hashes <= i_cfg_data[NH_W-1:0];
                default:        r_table_bits <= r_table_bits;
            endcase
        end
    end

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_cnt      <= '0;
            r_probe    <= '0;
        end else begin
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (r_state == ST_MOD_F || r_state == ST_MOD_S || r_state == ST_MOD_W) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end
            if (r_state == ST_CHK && !probe_last) begin
                r_probe <= r_probe + NH_W'(1);
            end else if (r_state != ST_RD && r_state != ST_CHK) begin
                r_probe <= '0;
            end
        end
    end

    // remainder passes and probe residues
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    r_cmd    <= i_cmd;
                    r_second <= i_hash_second;
                    r_acc    <= i_hash_first;
                    r_sh     <= i_hash_first;
                    r_rem    <= '0;
                end
            end
            ST_MOD_F, ST_MOD_S, ST_MOD_W: begin
                if (mod_done) begin
                    r_sh <= (r_state == ST_MOD_F) ? r_second : '0;
                    if (r_state == ST_MOD_S) begin
                        // 2^64 mod m: start from 1 mod m, shift in 64 zeros
                        r_rem <= (m_eff == TB_W'(1)) ? '0 : IDX_W'(1);
                    end else begin
                        r_rem <= '0;
                    end
                    if (r_state == ST_MOD_F) begin
                        r_idx <= mod_next;
                    end
                    if (r_state == ST_MOD_S) begin
                        r_smod <= mod_next;
                    end
                    if (r_state == ST_MOD_W) begin
                        r_wmod <= mod_next;
                    end
                end else begin
                    r_sh  <= {r_sh[HASH_W-2:0], 1'b0};
                    r_rem <= mod_next;
                end
            end
            ST_RD: begin
                r_part  <= step_part;
                r_carry <= acc_sum[HASH_W];
                r_acc   <= acc_sum[HASH_W-1:0];
            end
            ST_CHK: begin
                r_idx <= idx_next;
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    // bit array write side
    always_comb begin
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = (r_state == ST_CHK) && (r_cmd == CMD_INSERT);
            mem_waddr = r_idx[IDX_W-1:BIT_W];
            mem_wdata = r_rdata | bit_mask;
        end
    end

    // bit array, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[r_idx[IDX_W-1:BIT_W]];
    end

    // outputs
    assign busy      = (r_state != ST_IDLE);
    assign o_valid   = r_valid;
    assign o_present = r_present;

    // checks
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not make the engine busy");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && $past(busy))
        else $error("result strobe outside the end of an item");

    a_insert_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_cmd == CMD_INSERT) |-> !o_present)
        else $error("insert reported present");

    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_probe < NH_CAP)
        else $error("probe counter past the probe limit");

endmodule

`default_nettype wire

### sim/tb_bloom_filter_insert_query.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bloom_filter_insert_query
// Drives insert and query items with random idling through several table
// sizes and probe counts, mirrors the bit array in a shadow model and checks
// every present flag against it in order of issue.
// ----------------------------------------------------------------------------
module tb_bloom_filter_insert_query;
    import bfiq_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_SEGMENTS = 12;
    localparam int SEGMENT_ITEMS   = 44;
    localparam int KEY_POOL_DEPTH  = 48;
    localparam int DRAIN_CYCLES    = 400;

    // shadow of the bit array and registers, with the queue of expected flags
    class bloom_shadow;
        bit [WORD_W-1:0] words [MAP_WORDS];
        bit [TB_W-1:0]   table_bits;
        bit [NH_W-1:0]   num_hashes;
        bit              present_q[$];
        int              errors;

        function new();
            table_bits = TB_RESET;
            num_hashes = NH_RESET;
            errors     = 0;
        endfunction

        function void write_reg(logic idx, logic [TB_W-1:0] data);
            if (idx == REG_TABLE_BITS) begin
                table_bits = data;
            end else begin
                num_hashes = data[NH_W-1:0];
            end
        endfunction

        // walk the probe sequence: set bits on insert, test them on query
        function void note_item(logic cmd, logic [HASH_W-1:0] first,
                                logic [HASH_W-1:0] step);
            bit [HASH_W-1:0] modulus;
            bit [HASH_W-1:0] probe_no;
            bit [HASH_W-1:0] bit_idx;
            int unsigned     probes;
            int unsigned     word;
            bit              all_set;
            modulus = 64'(table_bits);
            if (modulus > 64'(MAP_WORDS) * WORD_W)
                modulus = 64'(MAP_WORDS) * WORD_W;
            if (modulus == 0)
                modulus = 64'd1;
            probes = 32'(num_hashes);
            if (probes > MAX_PROBES)
                probes = MAX_PROBES;
            all_set = 1'b1;
            for (int unsigned i = 0; i < probes; i++) begin
                probe_no = 64'(i);
                bit_idx  = (first + probe_no * step) % modulus;
                word     = 32'(bit_idx >> BIT_W);
                if (word >= MAP_WORDS)
                    word = MAP_WORDS - 1;
                if (cmd == CMD_INSERT) begin
                    words[word][bit_idx[BIT_W-1:0]] = 1'b1;
                end else if (!words[word][bit_idx[BIT_W-1:0]]) begin
                    all_set = 1'b0;
                    break;
                end
            end
            present_q.push_back((cmd == CMD_QUERY) ? all_set : 1'b0);
        endfunction

        function int pending();
            return present_q.size();
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_present(logic got);
            bit want;
            if (present_q.size() == 0) begin
                report("result strobe with no item outstanding");
            end else begin
                want = present_q.pop_front();
                if (got !== want)
                    report($sformatf("present %b, expected %b", got, want));
            end
        endtask
    endclass

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              start         = 1'b0;
    logic              busy;
    logic              i_cmd         = CMD_INSERT;
    logic [HASH_W-1:0] i_hash_first  = '0;
    logic [HASH_W-1:0] i_hash_second = '0;
    logic              o_valid;
    logic              o_present;
    logic              i_cfg_we      = 1'b0;
    logic              i_cfg_idx     = REG_TABLE_BITS;
    logic [TB_W-1:0]   i_cfg_data    = '0;

    bloom_shadow       shadow = new();
    int                sender_idle_pct = 0;
    int                cycle_count = 0;
    logic [HASH_W-1:0] pool_first[$];
    logic [HASH_W-1:0] pool_step[$];

    bloom_filter_insert_query dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_hash_first  (i_hash_first),
        .i_hash_second (i_hash_second),
        .o_valid       (o_valid),
        .o_present     (o_present),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result monitor, the receiver never stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            shadow.check_present(o_present);
    end

    function automatic logic [HASH_W-1:0] pick_hash();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return HASH_W'($urandom_range(255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // present one item, idling at random, until the engine takes it
    task automatic send_item(logic cmd, logic [HASH_W-1:0] first,
                             logic [HASH_W-1:0] step);
        bit taken;
        taken = 1'b0;
        while (!taken) begin
            if ($urandom_range(99) < sender_idle_pct) begin
                start <= 1'b0;
            end else begin
                start         <= 1'b1;
                i_cmd         <= cmd;
                i_hash_first  <= first;
                i_hash_second <= step;
            end
            @(posedge i_clk);
            if (start && !busy) begin
                shadow.note_item(cmd, first, step);
                taken = 1'b1;
            end
        end
        if (cmd == CMD_INSERT) begin
            pool_first.push_back(first);
            pool_step.push_back(step);
            if (pool_first.size() > KEY_POOL_DEPTH) begin
                void'(pool_first.pop_front());
                void'(pool_step.pop_front());
            end
        end
    endtask

    // hold off until every outstanding result has come back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (shadow.pending() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // both registers, back to back, only while idle
    task automatic write_cfg(logic [TB_W-1:0] table_bits, logic [NH_W-1:0] num_hashes);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_TABLE_BITS;
        i_cfg_data <= table_bits;
        @(posedge i_clk);
        shadow.write_reg(REG_TABLE_BITS, table_bits);
        i_cfg_idx  <= REG_NUM_HASHES;
        i_cfg_data <= {(TB_W - NH_W)'($urandom), num_hashes};
        @(posedge i_clk);
        shadow.write_reg(REG_NUM_HASHES, i_cfg_data);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        int                pick;
        int                slot;
        logic [TB_W-1:0]   tb_val;
        logic [NH_W-1:0]   nh_val;
        logic [HASH_W-1:0] first;
        logic [HASH_W-1:0] step;

        // reset, then let the clearing sweep finish
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);

        // reset settings: empty filter, then one key and the all-ones key
        send_item(CMD_QUERY,  '0, '0);
        send_item(CMD_INSERT, '0, '0);
        send_item(CMD_QUERY,  '0, '0);
        send_item(CMD_INSERT, '1, '1);
        send_item(CMD_QUERY,  '1, '1);

        // table size zero acts as one bit, most probes
        wait_drained();
        write_cfg('0, NH_W'(MAX_PROBES));
        send_item(CMD_INSERT, '1, 64'd5);
        send_item(CMD_QUERY,  {$urandom, $urandom}, {$urandom, $urandom});

        // oversized table and probe count saturate
        wait_drained();
        write_cfg('1, '1);
        send_item(CMD_INSERT, '1, '1);
        send_item(CMD_QUERY,  '1, '1);
        send_item(CMD_QUERY,  '1, '0);
        // first probe set, second clear: query stops early
        send_item(CMD_QUERY,  '0, 64'd1);

        // no probes: query always present, insert a no-op
        wait_drained();
        write_cfg(TB_W'(32), '0);
        send_item(CMD_QUERY,  {$urandom, $urandom}, {$urandom, $urandom});
        send_item(CMD_INSERT, {$urandom, $urandom}, {$urandom, $urandom});

        // single word table
        wait_drained();
        write_cfg(TB_W'(32), NH_W'(5));
        send_item(CMD_INSERT, 64'd3, 64'd7);
        send_item(CMD_QUERY,  64'd3, 64'd7);
        send_item(CMD_QUERY,  64'd3, 64'd8);

        // table just past one word
        wait_drained();
        write_cfg(TB_W'(33), NH_W'(3));
        send_item(CMD_INSERT, 64'd32, 64'd1);
        send_item(CMD_QUERY,  64'd32, 64'd1);

        // largest size below the cap, then a one-bit table
        wait_drained();
        write_cfg(TB_W'(1048575), NH_W'(2));
        send_item(CMD_INSERT, '1, 64'd1);
        send_item(CMD_QUERY,  '1, 64'd1);
        wait_drained();
        write_cfg(TB_W'(1), NH_W'(1));
        send_item(CMD_QUERY,  64'd123, 64'd456);
        send_item(CMD_INSERT, {$urandom, $urandom}, {$urandom, $urandom});

        // random segments, each with its own settings and idling
        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
            wait_drained();
            case ($urandom_range(9))
                0:       tb_val = '0;
                1:       tb_val = TB_W'(1);
                2:       tb_val = TB_RESET;
                3:       tb_val = '1;
                4, 5:    tb_val = TB_W'($urandom_range(1, 64));
                6, 7:    tb_val = TB_W'($urandom_range(65, 4096));
                default: tb_val = TB_W'($urandom);
            endcase
            case ($urandom_range(9))
                0:          nh_val = '0;
                1:          nh_val = NH_W'(MAX_PROBES);
                2:          nh_val = NH_W'($urandom_range(MAX_PROBES + 1, 127));
                3, 4, 5, 6: nh_val = NH_W'($urandom_range(1, 8));
                default:    nh_val = NH_W'($urandom_range(1, 40));
            endcase
            write_cfg(tb_val, nh_val);
            // receiver cannot stall, so its phases reduce to sender idling
            case (seg % 4)
                0:       sender_idle_pct = 0;
                1:       sender_idle_pct = 51;
                2:       sender_idle_pct = 0;
                default: sender_idle_pct = 29;
            endcase

            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                pick = $urandom_range(99);
                slot = (pool_first.size() > 0) ? $urandom_range(pool_first.size() - 1) : 0;
                if (pick < 45 || pool_first.size() == 0) begin
                    // fresh key inserted
                    send_item(CMD_INSERT, pick_hash(), pick_hash());
                end else if (pick < 80) begin
                    // known key queried
                    send_item(CMD_QUERY, pool_first[slot], pool_step[slot]);
                end else if (pick < 88) begin
                    // known base with a foreign step
                    send_item(CMD_QUERY, pool_first[slot], pick_hash());
                end else if (pick < 94) begin
                    // unknown key queried
                    send_item(CMD_QUERY, pick_hash(), pick_hash());
                end else begin
                    // known key inserted again
                    first = pool_first[slot];
                    step  = pool_step[slot];
                    send_item(CMD_INSERT, first, step);
                end
                // occasional full drain mid segment
                if ($urandom_range(39) == 0)
                    wait_drained();
            end
        end

        // drain and settle
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (shadow.pending() != 0)
            shadow.report($sformatf("%0d results never arrived", shadow.pending()));
        if (shadow.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### filelist.f
design/bfiq_pkg.sv
design/bloom_filter_insert_query.sv
sim/tb_bloom_filter_insert_query.sv
